FILE: hw/rtl/pose_frame_deframer_assert.svh
// Assertion helpers shared by the deframer RTL.
`ifndef POSE_FRAME_DEFRAMER_ASSERT_SVH
`define POSE_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pfd_pkg.sv
package pfd_pkg;

  // Frame layout
  localparam int FRAME_BYTES_DEF = 46;
  localparam int HDR_BYTES       = 4;
  localparam int WORD_COUNT      = 10;
  localparam int STAMP_WORD      = 9;
  localparam int PAY_END_FULL    = HDR_BYTES + 4 * WORD_COUNT;
  localparam int IDX_W           = $clog2(WORD_COUNT);
  localparam int POS_X_W         = 7;

  localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(WORD_COUNT - 1);

  // Configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLISH = 1'b1;
  localparam logic [31:0] HEADER_RESET  = 32'h7FAA_AAAA;
  localparam logic        PUBLISH_RESET = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_CKSUM   = 2'd1,
    KIND_LOST    = 2'd2
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic             hunt_step;
    logic             frame_step;
    logic             first_stamp;
    logic             good_frame;
    logic             clear_window;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             out_load;
    kind_t            out_kind;
    logic [IDX_W-1:0] out_index;
    logic             out_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hunt_match;
    logic pos_last;
    logic hdr_ok;
    logic sum_ok;
    logic out_free;
    logic publish;
  } status_t;

endpackage

FILE: hw/rtl/pfd_datapath.sv
module pfd_datapath #(
  parameter int FRAME_BYTES = pfd_pkg::FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]                     rx_byte,
  input  pfd_pkg::cmd_t                  cmd,
  output pfd_pkg::status_t               st,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     kind,
  output logic [pfd_pkg::IDX_W-1:0]      word_index,
  output logic [31:0]                    word_value,
  output logic [31:0]                    relative_stamp,
  output logic                           last_of_run
);
  import pfd_pkg::*;

  localparam int POS_W     = $clog2(FRAME_BYTES);
  localparam int PAY_LIMIT = (FRAME_BYTES - 2 < PAY_END_FULL) ? FRAME_BYTES - 2 : PAY_END_FULL;

  localparam logic [POS_W-1:0]   POS_LAST    = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0]   POS_CKA     = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0]   POS_FIRST   = POS_W'(HDR_BYTES);
  localparam logic [POS_X_W-1:0] X_HDR       = POS_X_W'(HDR_BYTES);
  localparam logic [POS_X_W-1:0] PAY_END     = POS_X_W'(PAY_LIMIT);
  localparam logic [POS_X_W-1:0] CK_END      = POS_X_W'(FRAME_BYTES - 2);
  localparam logic [POS_X_W-1:0] STAMP_START = POS_X_W'(HDR_BYTES + 4 * STAMP_WORD);

  // Configuration
  logic [31:0] header_pattern;
  logic        publish_enable;

  // Framing state
  logic [31:0]      hunt_window;
  logic [POS_W-1:0] pos;
  logic [7:0]       sum_a;
  logic [7:0]       sum_b;
  logic             have_start;
  logic [31:0]      start_stamp;

  // Frame capture
  logic [31:0] hdr_word;
  logic [31:0] stamp_word;
  logic [7:0]  cka_byte;
  logic [31:0] rel_q;
  logic [31:0] rd_q;
  logic [31:0] word_mem [WORD_COUNT];

  // Output register
  logic             out_valid_q;
  kind_t            out_kind_q;
  logic [IDX_W-1:0] out_index_q;
  logic [31:0]      out_value_q;
  logic [31:0]      out_rel_q;
  logic             out_last_q;

  logic [31:0]        window_next;
  logic [POS_X_W-1:0] pos_x;
  logic [POS_W-1:0]   pos_off;
  logic [IDX_W-1:0]   widx;
  logic [4:0]         lane_sh;
  logic               in_payload;
  logic               in_sum;
  logic               in_stamp;
  logic [7:0]         sum_a_add;
  logic [31:0]        stamp_diff;
  logic [31:0]        rd_mask;

  assign window_next = {rx_byte, hunt_window[31:8]};
  assign pos_x       = POS_X_W'(pos);
  assign pos_off     = pos - POS_FIRST;
  assign widx        = IDX_W'(pos_off[POS_W-1:2]);
  assign lane_sh     = {pos[1:0], 3'b000};
  assign in_payload  = (pos_x >= X_HDR) && (pos_x < PAY_END);
  assign in_sum      = (pos_x >= X_HDR) && (pos_x < CK_END);
  assign in_stamp    = in_payload && (pos_x >= STAMP_START);
  assign sum_a_add   = sum_a + rx_byte;
  assign stamp_diff  = stamp_word - start_stamp;

  // Bytes at or past the checksum read as zero
  always_comb begin
    logic [POS_X_W-1:0] lane_pos;
    rd_mask = '0;
    for (int l = 0; l < 4; l++) begin
      lane_pos = X_HDR + {1'b0, cmd.out_index, 2'b00} + POS_X_W'(l);
      rd_mask[8*l +: 8] = (lane_pos < CK_END) ? 8'hFF : 8'h00;
    end
  end

  // Status back to the controller
  always_comb begin
    st.hunt_match = (window_next == header_pattern);
    st.pos_last   = (pos == POS_LAST);
    st.hdr_ok     = (hdr_word == header_pattern);
    st.sum_ok     = (sum_a == cka_byte) && (sum_b == rx_byte);
    st.out_free   = !out_valid_q || !out_stall;
    st.publish    = publish_enable;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      header_pattern <= HEADER_RESET;
      publish_enable <= PUBLISH_RESET;
      hunt_window    <= '0;
      pos            <= '0;
      sum_a          <= '0;
      sum_b          <= '0;
      have_start     <= 1'b0;
      start_stamp    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_HEADER:  header_pattern <= cfg_data;
          CFG_PUBLISH: publish_enable <= cfg_data[0];
          default: ;
        endcase
      end
      // hunting: slide window, lock onto header
      if (cmd.hunt_step) begin
        hunt_window <= window_next;
        if (st.hunt_match) begin
          pos   <= POS_FIRST;
          sum_a <= '0;
          sum_b <= '0;
        end
      end
      if (cmd.clear_window) begin
        hunt_window <= '0;
      end
      // in-frame byte: position and Fletcher sums
      if (cmd.frame_step) begin
        pos <= st.pos_last ? '0 : pos + 1'b1;
        if (pos == '0) begin
          sum_a <= '0;
          sum_b <= '0;
        end else if (in_sum) begin
          sum_a <= sum_a_add;
          sum_b <= sum_b + sum_a_add;
        end
      end
      // start stamp from the first frame, re-based on negative difference
      if (cmd.first_stamp && !have_start) begin
        start_stamp <= stamp_word;
        have_start  <= 1'b1;
      end
      if (cmd.good_frame && stamp_diff[31]) begin
        start_stamp <= stamp_word;
      end
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Frame capture and output payload
  always_ff @(posedge clk) begin
    if (cmd.hunt_step && st.hunt_match) begin
      hdr_word   <= window_next;
      stamp_word <= '0;
    end
    if (cmd.frame_step) begin
      if (pos_x < X_HDR) begin
        hdr_word[lane_sh +: 8] <= rx_byte;
      end
      if (pos == '0) begin
        stamp_word <= '0;
      end else if (in_stamp) begin
        stamp_word[lane_sh +: 8] <= rx_byte;
      end
      if (pos == POS_CKA) begin
        cka_byte <= rx_byte;
      end
      if (in_payload) begin
        word_mem[widx][lane_sh +: 8] <= rx_byte;
      end
    end
    if (cmd.good_frame) begin
      rel_q <= stamp_diff[31] ? '0 : stamp_diff;
    end
    if (cmd.rd_en) begin
      rd_q <= word_mem[cmd.rd_addr];
    end
    if (cmd.out_load) begin
      out_kind_q  <= cmd.out_kind;
      out_index_q <= cmd.out_index;
      out_last_q  <= cmd.out_last;
      out_value_q <= (cmd.out_kind == KIND_PAYLOAD) ? (rd_q & rd_mask) : '0;
      out_rel_q   <= (cmd.out_kind == KIND_PAYLOAD) ? rel_q : '0;
    end
  end

  assign out_valid      = out_valid_q;
  assign kind           = out_kind_q;
  assign word_index     = out_index_q;
  assign word_value     = out_value_q;
  assign relative_stamp = out_rel_q;
  assign last_of_run    = out_last_q;

endmodule

FILE: hw/rtl/pfd_controller.sv
module pfd_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  pfd_pkg::status_t st,
  output pfd_pkg::cmd_t    cmd
);
  import pfd_pkg::*;

  typedef enum logic [5:0] {
    S_HUNT = 6'b000001,
    S_DROP = 6'b000010,
    S_SYNC = 6'b000100,
    S_ERR  = 6'b001000,
    S_READ = 6'b010000,
    S_LOAD = 6'b100000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic             err_lost;
  logic             err_lost_next;
  logic [IDX_W-1:0] word_k;
  logic [IDX_W-1:0] word_k_next;
  logic             accept;

  // Bytes are taken only in the framing states
  assign in_stall = !((state == S_HUNT) || (state == S_DROP) || (state == S_SYNC));
  assign accept   = in_valid && !in_stall;

  // Next state and commands
  always_comb begin
    state_next    = state;
    err_lost_next = err_lost;
    word_k_next   = word_k;
    cmd           = '0;
    cmd.out_kind  = KIND_PAYLOAD;
    unique case (state)
      S_HUNT: begin
        if (accept) begin
          cmd.hunt_step = 1'b1;
          if (st.hunt_match) state_next = S_DROP;
        end
      end
      S_DROP: begin
        if (accept) begin
          cmd.frame_step = 1'b1;
          if (st.pos_last) begin
            cmd.first_stamp = 1'b1;
            state_next      = S_SYNC;
          end
        end
      end
      S_SYNC: begin
        if (accept) begin
          cmd.frame_step = 1'b1;
          if (st.pos_last) begin
            if (!st.hdr_ok) begin
              cmd.clear_window = 1'b1;
              err_lost_next    = 1'b1;
              state_next       = S_ERR;
            end else if (!st.sum_ok) begin
              err_lost_next = 1'b0;
              state_next    = S_ERR;
            end else begin
              cmd.good_frame = 1'b1;
              if (st.publish) begin
                word_k_next = '0;
                state_next  = S_READ;
              end
            end
          end
        end
      end
      S_ERR: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = err_lost ? KIND_LOST : KIND_CKSUM;
          cmd.out_last = 1'b1;
          state_next   = err_lost ? S_HUNT : S_SYNC;
        end
      end
      S_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = word_k;
        state_next  = S_LOAD;
      end
      S_LOAD: begin
        cmd.out_index = word_k;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (word_k == LAST_WORD);
          if (word_k == LAST_WORD) begin
            state_next = S_SYNC;
          end else begin
            word_k_next = word_k + 1'b1;
            state_next  = S_READ;
          end
        end
      end
      default: state_next = S_HUNT;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_HUNT;
      err_lost <= 1'b0;
      word_k   <= '0;
    end else begin
      state    <= state_next;
      err_lost <= err_lost_next;
      word_k   <= word_k_next;
    end
  end

endmodule

FILE: hw/rtl/pose_frame_deframer.sv
// Byte in: one byte per cycle while framing; input stalls while results are produced.
// Error result: after the frame's last byte is taken, the error state loads it once the output register is free.
// Good frame (publishing on): ten payload words, each a word buffer read, then an output
// register load that waits while the output register is held by out_stall.
// Reset (synchronous, rst high): hunting, header 0x7FAAAAAA, publishing on,
// no start stamp; the word buffer is not cleared.
`include "pose_frame_deframer_assert.svh"

module pose_frame_deframer #(
  parameter int FRAME_BYTES = pfd_pkg::FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     kind,
  output logic [pfd_pkg::IDX_W-1:0]      word_index,
  output logic [31:0]                    word_value,
  output logic [31:0]                    relative_stamp,
  output logic                           last_of_run
);
  import pfd_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Sequencer
  pfd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Framing, checksum, word buffer and output register
  pfd_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .word_index     (word_index),
    .word_value     (word_value),
    .relative_stamp (relative_stamp),
    .last_of_run    (last_of_run)
  );

  // Checks
  `PFD_ASSERT_SAME(a_load_free, clk, rst, cmd.out_load, st.out_free, "result overwrote pending request")
  `PFD_ASSERT_SAME(a_step_accept, clk, rst, cmd.hunt_step || cmd.frame_step, in_valid && !in_stall, "byte step without accept")
  `PFD_ASSERT_SAME(a_err_last, clk, rst, out_valid && (kind != KIND_PAYLOAD), last_of_run, "error request not last")
  `PFD_ASSERT_NEXT(a_lost_stall, clk, rst, cmd.clear_window, in_stall, "input taken before lost-sync report")

endmodule

FILE: tb/sv/tb_pose_frame_deframer.sv
`timescale 1ns / 1ps

module tb_pose_frame_deframer;
  import pfd_pkg::*;

  localparam int FRAME_BYTES = FRAME_BYTES_DEF;
  localparam int STORE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] idx;
    logic [31:0]      value;
    logic [31:0]      rel;
    logic             last;
  } pose_result_t;

  typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_HDR} frame_e;
  typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_e;

  // Deframer predictor plus queue of pose results still owed by the block
  class pose_scoreboard;
    logic [31:0]  header_pat;
    logic         pub_en;
    logic [31:0]  window;
    bit           synced;
    bit           dropping;
    int           pos;
    logic [7:0]   sum_a;
    logic [7:0]   sum_b;
    logic [7:0]   store [STORE_DEPTH];
    bit           have_start;
    logic [31:0]  start_stamp;
    pose_result_t owed_q[$];
    int           errors;

    function new();
      header_pat  = HEADER_RESET;
      pub_en      = PUBLISH_RESET;
      window      = '0;
      synced      = 0;
      dropping    = 0;
      pos         = 0;
      sum_a       = '0;
      sum_b       = '0;
      have_start  = 0;
      start_stamp = '0;
      errors      = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == CFG_HEADER) header_pat = data;
      else if (idx == CFG_PUBLISH) pub_en = data[0];
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Bytes at or past the checksum read as zero
    function logic [7:0] pay_byte(int p);
      if (p + 2 >= FRAME_BYTES || p >= STORE_DEPTH) return 8'h00;
      return store[p];
    endfunction

    function logic [31:0] pay_word(int k);
      int p;
      p = HDR_BYTES + 4 * k;
      return {pay_byte(p + 3), pay_byte(p + 2), pay_byte(p + 1), pay_byte(p)};
    endfunction

    function void owe(kind_t kd, int idx, logic [31:0] value, logic [31:0] rel, bit last);
      pose_result_t r;
      r.kind  = kd;
      r.idx   = IDX_W'(idx);
      r.value = value;
      r.rel   = rel;
      r.last  = last;
      owed_q.push_back(r);
    endfunction

    // One accepted byte request
    function void note_request(logic [7:0] b);
      logic [31:0] stamp;
      logic [31:0] rel;
      if (!synced && !dropping) begin
        window = {b, window[31:8]};
        if (window == header_pat) begin
          store[0] = window[7:0];
          store[1] = window[15:8];
          store[2] = window[23:16];
          store[3] = window[31:24];
          dropping = 1;
          pos      = HDR_BYTES;
          sum_a    = '0;
          sum_b    = '0;
        end
        return;
      end
      store[pos] = b;
      if (pos == 0) begin
        sum_a = '0;
        sum_b = '0;
      end
      if (pos >= HDR_BYTES && pos + 2 < FRAME_BYTES) begin
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
      end
      if (pos + 1 < FRAME_BYTES) begin
        pos = pos + 1;
        return;
      end
      pos = 0;
      // sync frame: dropped, may set the start stamp
      if (dropping) begin
        dropping = 0;
        synced   = 1;
        if (!have_start) begin
          start_stamp = pay_word(STAMP_WORD);
          have_start  = 1;
        end
        return;
      end
      if ({store[3], store[2], store[1], store[0]} != header_pat) begin
        synced = 0;
        window = '0;
        owe(KIND_LOST, 0, '0, '0, 1'b1);
        return;
      end
      if (sum_a != store[FRAME_BYTES-2] || sum_b != store[FRAME_BYTES-1]) begin
        owe(KIND_CKSUM, 0, '0, '0, 1'b1);
        return;
      end
      // good frame: re-base when the stamp went backwards
      stamp = pay_word(STAMP_WORD);
      rel   = stamp - start_stamp;
      if (rel[31]) begin
        start_stamp = stamp;
        rel         = '0;
      end
      if (pub_en) begin
        for (int k = 0; k < WORD_COUNT; k++)
          owe(KIND_PAYLOAD, k, pay_word(k), rel, k == WORD_COUNT - 1);
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [1:0] got_kind, logic [IDX_W-1:0] got_idx,
                      logic [31:0] got_value, logic [31:0] got_rel, logic got_last);
      pose_result_t w;
      if (owed_q.size() == 0) begin
        report_mismatch("result with none pending, kind", 32'(got_kind), 'x);
        return;
      end
      w = owed_q.pop_front();
      if (got_kind !== w.kind) report_mismatch("kind", 32'(got_kind), 32'(w.kind));
      if (got_idx !== w.idx) report_mismatch("word_index", 32'(got_idx), 32'(w.idx));
      if (got_value !== w.value) report_mismatch("word_value", got_value, w.value);
      if (got_rel !== w.rel) report_mismatch("relative_stamp", got_rel, w.rel);
      if (got_last !== w.last) report_mismatch("last_of_run", 32'(got_last), 32'(w.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           kind;
  logic [IDX_W-1:0]     word_index;
  logic [31:0]          word_value;
  logic [31:0]          relative_stamp;
  logic                 last_of_run;

  pose_scoreboard sb = new();

  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;
  logic [31:0] stamp_run = '0;
  int          stall_mode = 0;
  int          stall_run = 0;
  int          mode_cycles = 0;

  pose_frame_deframer DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .word_index     (word_index),
    .word_value     (word_value),
    .relative_stamp (relative_stamp),
    .last_of_run    (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL pose_frame_deframer");
      $finish;
    end
  end

  // Result side: check, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result(kind, word_index, word_value, relative_stamp, last_of_run);
      if (mode_cycles == 0) begin
        stall_mode  = $urandom_range(0, 2);
        mode_cycles = $urandom_range(20, 120);
      end else begin
        mode_cycles--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            out_stall <= 1'b1;
          end else if ($urandom_range(0, 5) == 0) begin
            stall_run = $urandom_range(1, 12);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  // One byte request; bursts end in a random gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(b);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Hold off until every owed result is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly moving forward, sometimes backwards, sometimes anywhere
  function automatic logic [31:0] pick_stamp();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      stamp_run = stamp_run + $urandom_range(1, 2000);
      return stamp_run;
    end
    if (r < 8) return stamp_run - $urandom_range(1, 50000);
    return $urandom();
  endfunction

  // Build one frame with the current header; one_byte_hdr sends only its top byte
  task automatic send_frame(input frame_e fk, input bit one_byte_hdr, input fill_e fill,
                            input logic [31:0] stamp);
    logic [7:0] fr [0:FRAME_BYTES-1];
    logic [7:0] sa;
    logic [7:0] sbb;
    int         first;
    fr[0] = sb.header_pat[7:0];
    fr[1] = sb.header_pat[15:8];
    fr[2] = sb.header_pat[23:16];
    fr[3] = sb.header_pat[31:24];
    for (int i = HDR_BYTES; i < FRAME_BYTES - 2; i++) begin
      case (fill)
        FILL_ZERO: fr[i] = 8'h00;
        FILL_ONES: fr[i] = 8'hFF;
        default:   fr[i] = 8'($urandom_range(0, 255));
      endcase
    end
    {fr[HDR_BYTES+4*STAMP_WORD+3], fr[HDR_BYTES+4*STAMP_WORD+2],
     fr[HDR_BYTES+4*STAMP_WORD+1], fr[HDR_BYTES+4*STAMP_WORD]} = stamp;
    sa  = '0;
    sbb = '0;
    for (int i = HDR_BYTES; i < FRAME_BYTES - 2; i++) begin
      sa  = sa + fr[i];
      sbb = sbb + sa;
    end
    fr[FRAME_BYTES-2] = sa;
    fr[FRAME_BYTES-1] = sbb;
    case (fk)
      FR_BAD_SUM: begin
        first = $urandom_range(HDR_BYTES, FRAME_BYTES - 1);
        fr[first] = fr[first] ^ 8'(1 << $urandom_range(0, 7));
      end
      FR_BAD_HDR: begin
        first = $urandom_range(0, HDR_BYTES - 1);
        fr[first] = fr[first] ^ 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    first = one_byte_hdr ? HDR_BYTES - 1 : 0;
    for (int i = first; i < FRAME_BYTES; i++) send_byte(fr[i]);
  endtask

  // Reach a frame boundary while synchronized
  task automatic align_to_frame();
    while (!(sb.synced && !sb.dropping && sb.pos == 0)) begin
      if (!sb.synced && !sb.dropping) send_frame(FR_GOOD, 0, FILL_RAND, pick_stamp());
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly well-formed frames, some broken ones and loose noise bytes
  task automatic run_random(input int n_bytes);
    int base;
    int r;
    fill_e f;
    base = bytes_sent;
    while (bytes_sent - base < n_bytes) begin
      r = $urandom_range(0, 99);
      f = ($urandom_range(0, 9) != 0) ? FILL_RAND :
          ($urandom_range(0, 1) != 0) ? FILL_ONES : FILL_ZERO;
      if (r < 60) send_frame(FR_GOOD, 0, f, pick_stamp());
      else if (r < 75) send_frame(FR_BAD_SUM, 0, f, pick_stamp());
      else if (r < 85) send_frame(FR_BAD_HDR, 0, f, pick_stamp());
      else repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: extreme bytes, a near-miss header, then stamp edge cases
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'h7F);
    send_frame(FR_GOOD, 0, FILL_ONES, 32'hFFFF_FFF0);
    send_frame(FR_GOOD, 0, FILL_ZERO, 32'h0000_0005);
    send_frame(FR_GOOD, 0, FILL_ONES, 32'h8000_0010);
    send_frame(FR_BAD_SUM, 0, FILL_RAND, 32'h8000_0020);
    stamp_run = 32'h8000_0040;
    drain();

    // All-ones header
    write_reg(CFG_HEADER, 32'hFFFF_FFFF);
    run_random(20);
    drain();

    // Zero header, publishing off then on
    write_reg(CFG_HEADER, 32'h0000_0000);
    write_reg(CFG_PUBLISH, 32'd0);
    run_random(20);
    drain();
    write_reg(CFG_PUBLISH, 32'd1);

    // Header with zero low bytes matches on one byte after lost sync
    write_reg(CFG_HEADER, 32'hAB00_0000);
    align_to_frame();
    send_frame(FR_BAD_HDR, 0, FILL_RAND, pick_stamp());
    send_frame(FR_GOOD, 1, FILL_RAND, pick_stamp());
    send_frame(FR_GOOD, 0, FILL_RAND, pick_stamp());
    drain();

    // Random settings
    write_reg(CFG_HEADER, $urandom());
    write_reg(CFG_PUBLISH, 32'($urandom_range(0, 1)));
    run_random(20);
    drain();

    if (sb.errors == 0) begin
      $display("PASS pose_frame_deframer");
    end else begin
      $display("FAIL pose_frame_deframer");
    end
    $finish;
  end

endmodule
